FILE: rtl/psfutp_pkg.sv
// Shared types and constants for the PSF Unicode table parser.
`timescale 1ns / 1ps
`default_nettype none

package psfutp_pkg;

  localparam int GLYPH_W = 10;
  localparam logic [GLYPH_W-1:0] MAX_GLYPHS = 10'd512;
  localparam logic [GLYPH_W-1:0] GLYPH_COUNT_RESET = 10'd256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int BURST_MAX = 4;

  localparam logic REG_PSF2_MODE = 1'b0;
  localparam logic REG_GLYPH_COUNT = 1'b1;

  typedef enum logic [2:0] {
    KIND_MAP = 3'd0,
    KIND_GLYPH_END = 3'd1,
    KIND_OK = 3'd2,
    KIND_SHORT = 3'd3,
    KIND_TOO_LONG = 3'd4,
    KIND_CORRUPT = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_table;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [GLYPH_W-1:0] glyph_index;
    logic [7:0]         map_byte;
    logic               last;
  } result_t;

  typedef struct packed {
    kind_t                     kind;
    logic [GLYPH_W-1:0]        glyph;
    logic [1:0]                last_idx;
    logic [BURST_MAX-1:0][7:0] bytes;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/psf_unicode_table_parser_unit.sv
// Top level of the PSF Unicode table parser.
//
//   channel   direction  handshake               payload
//   item      in         item_valid/item_stall   item_data (stream_byte, end_of_table)
//   result    out        res_valid/res_stall     res_data (kind, glyph_index, map_byte, last)
//   cfg       in         cfg_write               cfg_index, cfg_data
//
// A byte is taken every cycle while the four-entry burst queue has room.
// Each byte yields zero to four results; they leave one per cycle from the
// output register while res_stall is low.
// Results pass through the burst queue and then the output register.
// Synchronous reset clears parser state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module psf_unicode_table_parser_unit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire                  cfg_index,
  input  wire [9:0]            cfg_data,
  input  wire                  item_valid,
  output logic                 item_stall,
  input  psfutp_pkg::item_t    item_data,
  output logic                 res_valid,
  input  wire                  res_stall,
  output psfutp_pkg::result_t  res_data
);

  psfutp_pkg::entry_t     push_entry;
  psfutp_pkg::entry_t     head;
  psfutp_pkg::q_status_t  q_status;
  logic                   push;
  logic                   pop;

  psfutp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_stall (item_stall),
    .q_status   (q_status),
    .push       (push),
    .entry      (push_entry)
  );

  psfutp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  psfutp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

`ifndef NO_ASSERTIONS
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.kind != psfutp_pkg::KIND_MAP) |-> res_data.last)
    else $error("status result not marked last");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res_data.last) |=> res_valid)
    else $error("gap inside a result burst");

  a_map_glyph_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.kind == psfutp_pkg::KIND_MAP)
      |-> (res_data.glyph_index < psfutp_pkg::MAX_GLYPHS))
    else $error("map byte for glyph beyond the cap");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("burst queue overflow");
`endif

endmodule

`default_nettype wire

FILE: rtl/psfutp_front.sv
// Front end: accepts table bytes, tracks parser state and builds result bursts.
`timescale 1ns / 1ps
`default_nettype none

module psfutp_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire                  cfg_index,
  input  wire [9:0]            cfg_data,
  input  wire                  item_valid,
  input  psfutp_pkg::item_t    item_data,
  output logic                 item_stall,
  input  psfutp_pkg::q_status_t q_status,
  output logic                 push,
  output psfutp_pkg::entry_t   entry
);

  logic                              psf2_mode;
  logic [psfutp_pkg::GLYPH_W-1:0]    glyph_count;
  logic [psfutp_pkg::GLYPH_W-1:0]    current_glyph;
  logic [psfutp_pkg::GLYPH_W-1:0]    current_glyph_next;
  logic [7:0]                        held_bytes [3];
  logic [1:0]                        held_count;
  logic [1:0]                        held_count_next;
  logic [1:0]                        bytes_needed;
  logic [1:0]                        bytes_needed_next;
  logic                              halted;
  logic                              halted_next;

  logic                              accept;
  logic                              has_result;
  logic                              hold_we;
  logic [1:0]                        hold_idx;
  logic [psfutp_pkg::GLYPH_W-1:0]    limit;
  logic                              too_long;
  logic                              pending;
  logic [7:0]                        b;
  logic [15:0]                       code;

  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;
  assign push       = accept && has_result;

  assign b        = item_data.stream_byte;
  assign code     = {b, held_bytes[0]};
  assign limit    = (glyph_count < psfutp_pkg::MAX_GLYPHS) ? glyph_count
                                                           : psfutp_pkg::MAX_GLYPHS;
  assign too_long = current_glyph >= limit;
  assign pending  = psf2_mode ? (bytes_needed != 2'd0) : (held_count != 2'd0);

  always_comb begin
    current_glyph_next = current_glyph;
    held_count_next    = held_count;
    bytes_needed_next  = bytes_needed;
    halted_next        = halted;
    hold_we            = 1'b0;
    hold_idx           = 2'd0;
    has_result         = 1'b0;
    entry.kind         = psfutp_pkg::KIND_MAP;
    entry.glyph        = current_glyph;
    entry.last_idx     = 2'd0;
    entry.bytes        = '0;

    if (item_data.end_of_table) begin
      if (!halted) begin
        has_result = 1'b1;
        entry.kind = pending ? psfutp_pkg::KIND_SHORT : psfutp_pkg::KIND_OK;
      end
      current_glyph_next = '0;
      held_count_next    = 2'd0;
      bytes_needed_next  = 2'd0;
      halted_next        = 1'b0;
    end else if (!halted) begin
      if (!psf2_mode) begin
        if (held_count == 2'd0) begin
          if (too_long) begin
            has_result        = 1'b1;
            entry.kind        = psfutp_pkg::KIND_TOO_LONG;
            held_count_next   = 2'd0;
            bytes_needed_next = 2'd0;
            halted_next       = 1'b1;
          end else begin
            hold_we         = 1'b1;
            hold_idx        = 2'd0;
            held_count_next = 2'd1;
          end
        end else begin
          held_count_next = 2'd0;
          has_result      = 1'b1;
          if (code == 16'hffff) begin
            entry.kind         = psfutp_pkg::KIND_GLYPH_END;
            current_glyph_next = current_glyph + 1'b1;
          end else if (code < 16'h0080) begin
            entry.bytes[0] = code[7:0];
          end else if (code < 16'h0800) begin
            entry.bytes[0] = {3'b110, code[10:6]};
            entry.bytes[1] = {2'b10, code[5:0]};
            entry.last_idx = 2'd1;
          end else begin
            entry.bytes[0] = {4'b1110, code[15:12]};
            entry.bytes[1] = {2'b10, code[11:6]};
            entry.bytes[2] = {2'b10, code[5:0]};
            entry.last_idx = 2'd2;
          end
        end
      end else if (bytes_needed == 2'd0) begin
        if (too_long) begin
          has_result        = 1'b1;
          entry.kind        = psfutp_pkg::KIND_TOO_LONG;
          held_count_next   = 2'd0;
          bytes_needed_next = 2'd0;
          halted_next       = 1'b1;
        end else if (b == 8'hff) begin
          has_result         = 1'b1;
          entry.kind         = psfutp_pkg::KIND_GLYPH_END;
          current_glyph_next = current_glyph + 1'b1;
        end else if (b inside {[8'hc0:8'hfc]}) begin
          hold_we         = 1'b1;
          hold_idx        = 2'd0;
          held_count_next = 2'd1;
          if (b inside {[8'hc0:8'hdf]}) begin
            bytes_needed_next = 2'd1;
          end else if (b inside {[8'he0:8'hef]}) begin
            bytes_needed_next = 2'd2;
          end else begin
            bytes_needed_next = 2'd3;
          end
        end else begin
          has_result     = 1'b1;
          entry.bytes[0] = b;
        end
      end else begin
        if (b > 8'hfd) begin
          has_result        = 1'b1;
          entry.kind        = psfutp_pkg::KIND_CORRUPT;
          held_count_next   = 2'd0;
          bytes_needed_next = 2'd0;
          halted_next       = 1'b1;
        end else if (bytes_needed == 2'd1) begin
          has_result = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_count) begin
              entry.bytes[i] = held_bytes[i];
            end
          end
          entry.bytes[held_count] = b;
          entry.last_idx          = held_count;
          held_count_next         = 2'd0;
          bytes_needed_next       = 2'd0;
        end else begin
          hold_we           = 1'b1;
          hold_idx          = (held_count == 2'd3) ? 2'd2 : held_count;
          held_count_next   = held_count + 1'b1;
          bytes_needed_next = bytes_needed - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      psf2_mode     <= 1'b1;
      glyph_count   <= psfutp_pkg::GLYPH_COUNT_RESET;
      current_glyph <= '0;
      held_count    <= 2'd0;
      bytes_needed  <= 2'd0;
      halted        <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == psfutp_pkg::REG_PSF2_MODE) begin
        psf2_mode    <= cfg_data[0];
        held_count   <= 2'd0;
        bytes_needed <= 2'd0;
      end else begin
        glyph_count <= cfg_data;
      end
    end else if (accept) begin
      current_glyph <= current_glyph_next;
      held_count    <= held_count_next;
      bytes_needed  <= bytes_needed_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_bytes[hold_idx] <= b;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psfutp_queue.sv
// Short burst queue between the front end and the result stage.
`timescale 1ns / 1ps
`default_nettype none

module psfutp_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  psfutp_pkg::entry_t     push_entry,
  input  wire                    pop,
  output psfutp_pkg::entry_t     head,
  output psfutp_pkg::q_status_t  q_status
);

  psfutp_pkg::entry_t               slots [psfutp_pkg::QUEUE_DEPTH];
  logic [psfutp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [psfutp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [psfutp_pkg::QCNT_W-1:0]    count;

  assign head           = slots[rd_ptr];
  assign q_status.full  = count == psfutp_pkg::QCNT_W'(psfutp_pkg::QUEUE_DEPTH);
  assign q_status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psfutp_back.sv
// Result stage: plays each queued burst out one result per transfer.
`timescale 1ns / 1ps
`default_nettype none

module psfutp_back (
  input  wire                    clk,
  input  wire                    rst,
  input  psfutp_pkg::entry_t     head,
  input  psfutp_pkg::q_status_t  q_status,
  output logic                   pop,
  output logic                   res_valid,
  input  wire                    res_stall,
  output psfutp_pkg::result_t    res_data
);

  psfutp_pkg::entry_t cur;
  logic [1:0]         idx;
  logic               at_last;
  logic               done;

  assign at_last = idx == cur.last_idx;
  assign done    = !res_valid || (!res_stall && at_last);
  assign pop     = done && !q_status.empty;

  assign res_data.kind        = cur.kind;
  assign res_data.glyph_index = cur.glyph;
  assign res_data.map_byte    = cur.bytes[idx];
  assign res_data.last        = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      res_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (res_valid && !res_stall) begin
      if (at_last) begin
        res_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

`default_nettype wire
